/* design/sact_pkg.sv */
package sact_pkg;

  // sizing of the tag store
  localparam int MAX_SETS   = 256;
  localparam int WAYS       = 8;
  localparam int ADDR_BITS  = 48;
  localparam int STAMP_BITS = 32;

  localparam int SET_W  = (MAX_SETS > 1) ? $clog2(MAX_SETS) : 1;
  localparam int WAY_W  = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int CNT_W  = ($clog2(WAYS + 1) > 4) ? $clog2(WAYS + 1) : 4;
  localparam int TREE_N = 1 << $clog2(WAYS);

  // stream payload widths
  localparam int IN_W      = ((ADDR_BITS + 7) / 8) * 8;
  localparam int OUT_BITS  = ADDR_BITS + 4;
  localparam int OUT_W     = ((OUT_BITS + 7) / 8) * 8;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_W     = 4;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_OFFSET_BITS = 3'd0,
    REG_INDEX_BITS  = 3'd1,
    REG_WAYS_USED   = 3'd2,
    REG_STORE_THRU  = 3'd3,
    REG_WR_ALLOC    = 3'd4
  } cfg_reg_t;

  typedef struct packed {
    logic [3:0] offset_bits;
    logic [3:0] index_bits;
    logic [3:0] ways_used;
    logic       store_thru;
    logic       wr_alloc;
  } cfg_t;

  typedef struct packed {
    logic                  valid;
    logic                  dirty;
    logic [ADDR_BITS-1:0]  tag;
    logic [STAMP_BITS-1:0] stamp;
  } way_t;

  typedef way_t [WAYS-1:0] row_t;

  localparam int ROW_W = $bits(row_t);

  // hit sits in bit 0
  typedef struct packed {
    logic [ADDR_BITS-1:0] writeback_addr;
    logic                 writeback_valid;
    logic                 allocated;
    logic                 lower_request;
    logic                 hit;
  } res_t;

  // index width actually used, clamped to the sets that exist
  function automatic logic [3:0] index_used(input cfg_t cfg);
    logic [3:0] s;
    s = cfg.index_bits;
    if (s > 4'(SET_W)) begin
      s = 4'(SET_W);
    end
    return s;
  endfunction

  function automatic logic [SET_W-1:0] set_of(input logic [ADDR_BITS-1:0] addr,
                                               input cfg_t cfg);
    logic [ADDR_BITS-1:0] shifted;
    logic [SET_W-1:0]     mask;
    shifted = addr >> cfg.offset_bits;
    mask    = ~({SET_W{1'b1}} << index_used(cfg));
    return shifted[SET_W-1:0] & mask;
  endfunction

endpackage

/* design/sact_ram.sv */
module sact_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* design/sact_lookup.sv */
module sact_lookup (
  input  sact_pkg::row_t                       row_q,
  input  logic [sact_pkg::ADDR_BITS-1:0]       addr,
  input  logic                                 is_write,
  input  logic [sact_pkg::SET_W-1:0]           set_idx,
  input  sact_pkg::cfg_t                       cfg,
  input  logic [sact_pkg::STAMP_BITS-1:0]      now,
  output sact_pkg::res_t                       res,
  output sact_pkg::row_t                       row_upd
);

  import sact_pkg::*;

  logic [3:0]            b;
  logic [3:0]            s;
  logic [4:0]            sh;
  logic [CNT_W-1:0]      nw;
  logic [ADDR_BITS-1:0]  tag;
  logic                  hit_found;
  logic [WAY_W-1:0]      hit_way;
  logic                  inv_found;
  logic [WAY_W-1:0]      inv_way;
  logic [STAMP_BITS-1:0] n_age [1:2*TREE_N-1];
  logic [WAY_W-1:0]      n_idx [1:2*TREE_N-1];
  logic                  n_ok  [1:2*TREE_N-1];

  // request decode and way search
  always_comb begin
    b  = cfg.offset_bits;
    s  = index_used(cfg);
    sh = 5'(b) + 5'(s);
    tag = addr >> sh;

    nw = CNT_W'(cfg.ways_used);
    if (nw == '0) begin
      nw = CNT_W'(1);
    end else if (nw > CNT_W'(WAYS)) begin
      nw = CNT_W'(WAYS);
    end

    hit_found = 1'b0;
    hit_way   = '0;
    inv_found = 1'b0;
    inv_way   = '0;
    for (int w = WAYS - 1; w >= 0; w--) begin
      if (CNT_W'(w) < nw) begin
        if (row_q[w].valid && row_q[w].tag == tag) begin
          hit_found = 1'b1;
          hit_way   = WAY_W'(w);
        end
        if (!row_q[w].valid) begin
          inv_found = 1'b1;
          inv_way   = WAY_W'(w);
        end
      end
    end
  end

  // oldest-stamp tree, left wins ties so the lowest way is picked
  always_comb begin
    for (int i = 0; i < TREE_N; i++) begin
      if (i < WAYS) begin
        n_age[TREE_N+i] = now - row_q[i].stamp;
        n_ok[TREE_N+i]  = CNT_W'(i) < nw;
        n_idx[TREE_N+i] = WAY_W'(i);
      end else begin
        n_age[TREE_N+i] = '0;
        n_ok[TREE_N+i]  = 1'b0;
        n_idx[TREE_N+i] = '0;
      end
    end
    for (int n = TREE_N - 1; n >= 1; n--) begin
      if (n_ok[2*n] && (!n_ok[2*n+1] || n_age[2*n] >= n_age[2*n+1])) begin
        n_age[n] = n_age[2*n];
        n_idx[n] = n_idx[2*n];
      end else begin
        n_age[n] = n_age[2*n+1];
        n_idx[n] = n_idx[2*n+1];
      end
      n_ok[n] = n_ok[2*n] || n_ok[2*n+1];
    end
  end

  // result and updated row
  always_comb begin
    logic [WAY_W-1:0] vic;
    logic             fill;
    vic     = inv_found ? inv_way : n_idx[1];
    fill    = !hit_found && !(is_write && !cfg.wr_alloc);
    row_upd = row_q;
    res     = '0;
    res.hit = hit_found;

    if (hit_found) begin
      row_upd[hit_way].stamp = now;
      if (is_write) begin
        if (cfg.store_thru) begin
          res.lower_request = 1'b1;
        end else begin
          row_upd[hit_way].dirty = 1'b1;
        end
      end
    end else begin
      res.lower_request = 1'b1;
      if (fill) begin
        res.allocated = 1'b1;
        if (!inv_found && !cfg.store_thru && row_q[vic].dirty) begin
          res.writeback_valid = 1'b1;
          res.writeback_addr  = (row_q[vic].tag << sh) |
                                (ADDR_BITS'(set_idx) << b);
        end
        row_upd[vic].valid = 1'b1;
        row_upd[vic].dirty = is_write && !cfg.store_thru;
        row_upd[vic].tag   = tag;
        row_upd[vic].stamp = now;
      end
    end
  end

endmodule

/* design/set_assoc_cache_tag_controller_core.sv */
// an accepted request waits in the request stage and moves to the output register when free or draining
// throughput: one request per cycle when not stalled; the set row ram is read at accept and written back
//   as the request moves on, with a forward path for back-to-back requests to the same set
// reset (synchronous, rst high): pipeline and output emptied, request counter cleared, config
//   back to offset 6 / index 8 / ways 8 / write-back / write-allocate, every set row marked empty
module set_assoc_cache_tag_controller_core (
  input  logic                           clk,
  input  logic                           rst,
  // request stream
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  input  logic [sact_pkg::IN_W-1:0]      s_axis_tdata,   // [47:0] addr
  input  logic                           s_axis_tuser,   // [0] is_write
  // result stream
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  // [0] hit, [1] lower_request, [2] allocated, [3] writeback_valid,
  // [51:4] writeback_addr, rest zero
  output logic [sact_pkg::OUT_W-1:0]     m_axis_tdata,
  // configuration writes
  input  logic                           cfg_we,
  input  logic [sact_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [sact_pkg::CFG_W-1:0]     cfg_data
);

  import sact_pkg::*;

  // configuration registers
  cfg_t cfg;

  // request stage: holds the request while its set row comes out of the ram
  logic                  req_valid;
  logic [ADDR_BITS-1:0]  req_addr;
  logic                  req_write;
  logic [SET_W-1:0]      req_set;

  // forward path: row written in the same cycle the next request read it
  logic                  fwd_valid;
  row_t                  fwd_row;

  // one flag per set row; a row never written reads as all lines empty
  logic [MAX_SETS-1:0]   row_valid;

  logic [STAMP_BITS-1:0] request_count;

  // output register
  res_t                  out_res;

  logic                  in_xfer;
  logic                  req_fire;
  logic [ADDR_BITS-1:0]  in_addr;
  logic [SET_W-1:0]      in_set;
  logic [ROW_W-1:0]      ram_q;
  row_t                  row_cur;
  row_t                  row_upd;
  res_t                  res;

  assign in_addr       = s_axis_tdata[ADDR_BITS-1:0];
  assign in_set        = set_of(in_addr, cfg);
  // request leaves the request stage whenever the output register is free or being drained
  assign req_fire      = req_valid && (!m_axis_tvalid || m_axis_tready);
  assign s_axis_tready = !req_valid || req_fire;
  assign in_xfer       = s_axis_tvalid && s_axis_tready;

  // configuration writes, unknown indexes dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.offset_bits <= 4'd6;
      cfg.index_bits  <= 4'd8;
      cfg.ways_used   <= 4'd8;
      cfg.store_thru  <= 1'b0;
      cfg.wr_alloc    <= 1'b1;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_OFFSET_BITS: cfg.offset_bits <= cfg_data;
        REG_INDEX_BITS:  cfg.index_bits  <= cfg_data;
        REG_WAYS_USED:   cfg.ways_used   <= cfg_data;
        REG_STORE_THRU:  cfg.store_thru  <= cfg_data[0];
        REG_WR_ALLOC:    cfg.wr_alloc    <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // set row store: tag, stamp, valid and dirty of every way in one word
  sact_ram #(
    .WIDTH (ROW_W),
    .DEPTH (MAX_SETS)
  ) u_row_ram (
    .clk   (clk),
    .we    (req_fire),
    .waddr (req_set),
    .wdata (row_upd),
    .re    (in_xfer),
    .raddr (in_set),
    .rdata (ram_q)
  );

  // pick the freshest copy of the row
  always_comb begin
    if (fwd_valid) begin
      row_cur = fwd_row;
    end else if (row_valid[req_set]) begin
      row_cur = row_t'(ram_q);
    end else begin
      row_cur = '0;
    end
  end

  sact_lookup u_lookup (
    .row_q    (row_cur),
    .addr     (req_addr),
    .is_write (req_write),
    .set_idx  (req_set),
    .cfg      (cfg),
    .now      (request_count),
    .res      (res),
    .row_upd  (row_upd)
  );

  // request stage and forward capture
  always_ff @(posedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
      fwd_valid <= 1'b0;
    end else begin
      if (in_xfer) begin
        req_valid <= 1'b1;
        fwd_valid <= req_fire && (req_set == in_set);
      end else if (req_fire) begin
        req_valid <= 1'b0;
        fwd_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      req_addr  <= in_addr;
      req_write <= s_axis_tuser;
      req_set   <= in_set;
      fwd_row   <= row_upd;
    end
  end

  // row flags and lru clock advance with each finished request
  always_ff @(posedge clk) begin
    if (rst) begin
      row_valid     <= '0;
      request_count <= '0;
    end else if (req_fire) begin
      row_valid[req_set] <= 1'b1;
      request_count      <= request_count + 1'b1;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (req_fire) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (req_fire) begin
      out_res <= res;
    end
  end

  assign m_axis_tdata = OUT_W'(out_res);

`ifndef SYNTHESIS
  // a finished request always lands in the output register
  a_fire_to_out: assert property (@(posedge clk) disable iff (rst)
    req_fire |=> m_axis_tvalid)
    else $error("request left the request stage without a result");

  // forwarding only ever applies to a request that is waiting
  a_fwd_req: assert property (@(posedge clk) disable iff (rst)
    fwd_valid |-> req_valid)
    else $error("forward flag set with no request pending");

  // a hit never fills a line, and a writeback only comes with a fill
  a_res_flags: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> !(out_res.hit && out_res.allocated) &&
                      (!out_res.writeback_valid || out_res.allocated))
    else $error("inconsistent hit, fill and writeback flags");

  // every miss goes to the lower level
  a_miss_lower: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !out_res.hit |-> out_res.lower_request)
    else $error("miss not passed to lower level");
`endif

endmodule

/* tb/sv/tb_set_assoc_cache_tag_controller_core.sv */
`timescale 1ns / 1ps

module tb_set_assoc_cache_tag_controller_core;
  import sact_pkg::*;

  // index with no register behind it, writes there must be ignored
  localparam logic [CFG_IDX_W-1:0] REG_SPARE = 3'd7;

  localparam int PHASES = 8;
  localparam int PHASE_ITEMS = 156;
  localparam int POOL_N = 12;

  typedef enum logic {
    ROW_REQ,
    ROW_CFG
  } row_kind_t;

  // one line of the directed table: either a request or a full register setting
  typedef struct {
    row_kind_t        kind;
    logic [47:0]      addr;
    logic             wr;
    logic             pinned;  // exp typed in by hand, else predicted
    res_t             exp;
    cfg_t             cfg;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [IN_W-1:0]      s_axis_tdata = '0;   // [47:0] addr
  logic                 s_axis_tuser = 1'b0; // [0] is_write
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  // [0] hit, [1] lower_request, [2] allocated, [3] writeback_valid, [51:4] writeback_addr
  logic [OUT_W-1:0]     m_axis_tdata;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0]     cfg_data = '0;

  // idle rates in percent, changed only between phases
  int src_idle_pct = 0;
  int sink_stall_pct = 0;

  // predictor copy of the tag store and registers
  bit          way_valid [MAX_SETS][WAYS];
  bit          way_dirty [MAX_SETS][WAYS];
  logic [47:0] way_tag   [MAX_SETS][WAYS];
  logic [31:0] way_stamp [MAX_SETS][WAYS];
  logic [31:0] access_count;
  logic [3:0]  cur_off;
  logic [3:0]  cur_idx;
  logic [3:0]  cur_ways;
  logic        cur_wt;
  logic        cur_wa;

  res_t pending_lookups[$];
  int   lookup_errors = 0;

  dir_row_t directed_rows[$];
  cfg_t     phase_cfgs[PHASES];

  set_assoc_cache_tag_controller_core dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  // 2 ns clock
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // lookup of one request against the predictor's tag store; updates lru stamps,
  // valid and dirty bits the same way the block is meant to
  function automatic res_t cache_lookup(input logic [47:0] a, input logic wr);
    res_t        r;
    int          b;
    int          s;
    int          nw;
    int          v;
    int          hit_way;
    logic [63:0] set_i;
    logic [63:0] tag_i;
    logic [63:0] wide;
    logic [31:0] now;
    logic [31:0] age;
    logic [31:0] oldest;
    r = '0;
    b = int'(cur_off);
    // index clamps to the sets that exist, ways to at least one and at most all
    s = (int'(cur_idx) > SET_W) ? SET_W : int'(cur_idx);
    nw = (cur_ways == 4'd0) ? 1 : (int'(cur_ways) > WAYS) ? WAYS : int'(cur_ways);
    set_i = (64'(a) >> b) & ((64'd1 << s) - 64'd1);
    tag_i = 64'(a) >> (b + s);
    now = access_count;
    hit_way = -1;
    for (int w = 0; w < nw; w++) begin
      if (hit_way < 0 && way_valid[set_i][w] && way_tag[set_i][w] == tag_i[47:0]) begin
        hit_way = w;
      end
    end
    if (hit_way >= 0) begin
      r.hit = 1'b1;
      way_stamp[set_i][hit_way] = now;
      // write hit: forwarded in write-through, marked dirty in write-back
      if (wr && cur_wt) begin
        r.lower_request = 1'b1;
      end else if (wr) begin
        way_dirty[set_i][hit_way] = 1'b1;
      end
    end else begin
      r.lower_request = 1'b1;
      // write miss without allocate leaves the store untouched
      if (!wr || cur_wa) begin
        v = nw;
        for (int w = nw - 1; w >= 0; w--) begin
          if (!way_valid[set_i][w]) begin
            v = w;
          end
        end
        if (v == nw) begin
          // all ways full: oldest stamp loses, ties go to the lowest way
          v = 0;
          oldest = now - way_stamp[set_i][0];
          for (int w = 1; w < nw; w++) begin
            age = now - way_stamp[set_i][w];
            if (age > oldest) begin
              oldest = age;
              v = w;
            end
          end
          // dirty victims are flushed only in write-back mode
          if (!cur_wt && way_dirty[set_i][v]) begin
            r.writeback_valid = 1'b1;
            wide = (64'(way_tag[set_i][v]) << (b + s)) | (set_i << b);
            r.writeback_addr = wide[47:0];
          end
        end
        way_valid[set_i][v] = 1'b1;
        way_dirty[set_i][v] = wr && !cur_wt;
        way_tag[set_i][v] = tag_i[47:0];
        way_stamp[set_i][v] = now;
        r.allocated = 1'b1;
      end
    end
    access_count = access_count + 32'd1;
    return r;
  endfunction

  function automatic dir_row_t req_row(input logic [47:0] a, input logic wr);
    dir_row_t row;
    row = '{kind: ROW_REQ, addr: a, wr: wr, pinned: 1'b0, exp: '0, cfg: '0};
    return row;
  endfunction

  function automatic dir_row_t pinned_row(input logic [47:0] a, input logic wr,
                                          input logic h, input logic lo, input logic al,
                                          input logic wbv, input logic [47:0] wba);
    dir_row_t row;
    row = req_row(a, wr);
    row.pinned = 1'b1;
    row.exp.hit = h;
    row.exp.lower_request = lo;
    row.exp.allocated = al;
    row.exp.writeback_valid = wbv;
    row.exp.writeback_addr = wba;
    return row;
  endfunction

  function automatic dir_row_t cfg_row(input logic [3:0] off, input logic [3:0] idx,
                                       input logic [3:0] ways, input logic wt,
                                       input logic wa);
    dir_row_t row;
    row = req_row('0, 1'b0);
    row.kind = ROW_CFG;
    row.cfg = '{offset_bits: off, index_bits: idx, ways_used: ways,
                store_thru: wt, wr_alloc: wa};
    return row;
  endfunction

  task automatic flag_lookup(input string msg);
    $display("mismatch at %0t ns: %s", $time, msg);
    lookup_errors++;
  endtask

  // one register write per rising edge, predictor follows at that edge
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    case (idx)
      REG_OFFSET_BITS: begin
        cur_off = val;
      end
      REG_INDEX_BITS: begin
        cur_idx = val;
      end
      REG_WAYS_USED: begin
        cur_ways = val;
      end
      REG_STORE_THRU: begin
        cur_wt = val[0];
      end
      REG_WR_ALLOC: begin
        cur_wa = val[0];
      end
      default: begin
      end
    endcase
  endtask

  // writes every register, upper data bits of the flag registers are junk
  task automatic apply_cfg(input cfg_t c);
    write_reg(REG_OFFSET_BITS, c.offset_bits);
    write_reg(REG_INDEX_BITS, c.index_bits);
    write_reg(REG_WAYS_USED, c.ways_used);
    write_reg(REG_STORE_THRU, {3'($urandom_range(0, 7)), c.store_thru});
    write_reg(REG_WR_ALLOC, {3'($urandom_range(0, 7)), c.wr_alloc});
    write_reg(REG_SPARE, 4'($urandom));
    cfg_we <= 1'b0;
  endtask

  // drop valid and wait until every issued request has come back
  task automatic settle();
    s_axis_tvalid <= 1'b0;
    while (pending_lookups.size() != 0) begin
      @(posedge clk);
    end
  endtask

  // present one request, hold it until the transfer, then predict it
  task automatic send_req(input logic [47:0] a, input logic wr, input logic pinned,
                          input res_t exp);
    res_t model_res;
    // random gaps, with garbage on the data lines while idle
    while ($urandom_range(0, 99) < src_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata <= 48'({$urandom, $urandom});
      s_axis_tuser <= 1'($urandom);
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= a;
    s_axis_tuser <= wr;
    @(posedge clk);
    while (!s_axis_tready) begin
      @(posedge clk);
    end
    model_res = cache_lookup(a, wr);
    pending_lookups.push_back(pinned ? exp : model_res);
  endtask

  // result side backpressure
  always @(posedge clk) begin
    m_axis_tready <= ($urandom_range(0, 99) >= sink_stall_pct);
  end

  // every result transfer is matched against the oldest pending lookup
  always @(posedge clk) begin : result_check
    res_t got;
    res_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      got = res_t'(m_axis_tdata[OUT_BITS-1:0]);
      if (pending_lookups.size() == 0) begin
        flag_lookup($sformatf("result with no request pending, data %h", m_axis_tdata));
      end else begin
        want = pending_lookups.pop_front();
        if (got.hit !== want.hit) begin
          flag_lookup($sformatf("hit %b, expected %b", got.hit, want.hit));
        end
        if (got.lower_request !== want.lower_request) begin
          flag_lookup($sformatf("lower_request %b, expected %b",
                                got.lower_request, want.lower_request));
        end
        if (got.allocated !== want.allocated) begin
          flag_lookup($sformatf("allocated %b, expected %b", got.allocated, want.allocated));
        end
        if (got.writeback_valid !== want.writeback_valid) begin
          flag_lookup($sformatf("writeback_valid %b, expected %b",
                                got.writeback_valid, want.writeback_valid));
        end
        if (got.writeback_addr !== want.writeback_addr) begin
          flag_lookup($sformatf("writeback_addr %h, expected %h",
                                got.writeback_addr, want.writeback_addr));
        end
      end
    end
  end

  initial begin
    int          eff_s;
    logic [47:0] tag_pool [POOL_N];
    logic [47:0] addr;
    logic [63:0] set_pick;
    logic [63:0] wide;
    int          idle_src [4];
    int          idle_sink [4];

    // predictor starts from the reset state
    foreach (way_valid[i, j]) begin
      way_valid[i][j] = 1'b0;
      way_dirty[i][j] = 1'b0;
    end
    access_count = '0;
    cur_off = 4'd6;
    cur_idx = 4'd8;
    cur_ways = 4'd8;
    cur_wt = 1'b0;
    cur_wa = 1'b1;

    // no idling, sender idle, receiver stalling, both
    idle_src = '{0, 87, 0, 36};
    idle_sink = '{0, 0, 87, 36};

    // reset settings, then the extremes and odd corners of every register
    phase_cfgs[0] = '{4'd6, 4'd8, 4'd8, 1'b0, 1'b1};
    phase_cfgs[1] = '{4'd0, 4'd0, 4'd1, 1'b0, 1'b1};
    phase_cfgs[2] = '{4'd12, 4'd8, 4'd8, 1'b1, 1'b0};
    phase_cfgs[3] = '{4'd3, 4'd2, 4'd2, 1'b0, 1'b0};
    phase_cfgs[4] = '{4'd15, 4'd12, 4'd4, 1'b0, 1'b1};
    phase_cfgs[5] = '{4'd4, 4'd1, 4'd15, 1'b1, 1'b1};
    phase_cfgs[6] = '{4'd6, 4'd3, 4'd0, 1'b0, 1'b1};
    phase_cfgs[7] = '{4'd2, 4'd4, 4'd8, 1'b0, 1'b1};

    // reset settings: set 0 filled, lru victim is the dirty line of tag 0
    directed_rows.push_back(pinned_row(48'h0000_0000_0000, 1'b0, 0, 1, 1, 0, '0));
    directed_rows.push_back(pinned_row(48'h0000_0000_003F, 1'b0, 1, 0, 0, 0, '0));
    directed_rows.push_back(pinned_row(48'h0000_0000_0000, 1'b1, 1, 0, 0, 0, '0));
    directed_rows.push_back(pinned_row(48'hFFFF_FFFF_FFFF, 1'b0, 0, 1, 1, 0, '0));
    directed_rows.push_back(pinned_row(48'hFFFF_FFFF_FFFF, 1'b1, 1, 0, 0, 0, '0));
    for (int t = 1; t < 8; t++) begin
      directed_rows.push_back(pinned_row(48'(t) << 14, 1'b0, 0, 1, 1, 0, '0));
    end
    directed_rows.push_back(pinned_row(48'h0000_0002_0000, 1'b0, 0, 1, 1, 1, '0));
    // offset beyond the nominal range, index clamped to 8, zero ways acting as one,
    // write miss without allocate, dirty eviction with a high writeback address
    directed_rows.push_back(cfg_row(4'd15, 4'd15, 4'd0, 1'b0, 1'b0));
    directed_rows.push_back(pinned_row(48'h5555_5555_5555, 1'b1, 0, 1, 0, 0, '0));
    directed_rows.push_back(pinned_row(48'h5555_5555_5555, 1'b0, 0, 1, 1, 0, '0));
    directed_rows.push_back(pinned_row(48'h5555_5555_5555, 1'b1, 1, 0, 0, 0, '0));
    directed_rows.push_back(pinned_row(48'hD555_5555_5555, 1'b0, 0, 1, 1, 1,
                                       48'h5555_5555_0000));
    directed_rows.push_back(pinned_row(48'hD555_5555_5555, 1'b1, 1, 0, 0, 0, '0));
    // write-through: dirty line left over is dropped silently, write hit forwarded
    directed_rows.push_back(cfg_row(4'd15, 4'd15, 4'd0, 1'b1, 1'b1));
    directed_rows.push_back(pinned_row(48'h5555_5555_5555, 1'b0, 0, 1, 1, 0, '0));
    directed_rows.push_back(pinned_row(48'h5555_5555_5555, 1'b1, 1, 1, 0, 0, '0));
    directed_rows.push_back(pinned_row(48'hD555_5555_5555, 1'b1, 0, 1, 1, 0, '0));
    // single set, no offset, ways above the array clamp to all of them
    directed_rows.push_back(cfg_row(4'd0, 4'd0, 4'd9, 1'b0, 1'b1));
    directed_rows.push_back(req_row(48'h0000_0000_0001, 1'b1));
    directed_rows.push_back(req_row(48'hFFFF_FFFF_FFFF, 1'b0));
    directed_rows.push_back(req_row(48'h8000_0000_0000, 1'b1));

    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // directed table
    foreach (directed_rows[k]) begin
      if (directed_rows[k].kind == ROW_CFG) begin
        settle();
        apply_cfg(directed_rows[k].cfg);
      end else begin
        send_req(directed_rows[k].addr, directed_rows[k].wr, directed_rows[k].pinned,
                 directed_rows[k].exp);
      end
    end

    // random phases: each has its own register setting and idle pattern
    for (int p = 0; p < PHASES; p++) begin
      settle();
      src_idle_pct = idle_src[p % 4];
      sink_stall_pct = idle_sink[p % 4];
      apply_cfg(phase_cfgs[p]);
      eff_s = (int'(cur_idx) > SET_W) ? SET_W : int'(cur_idx);
      // a few small tags and some wide ones, so sets fill, hit and evict
      for (int i = 0; i < POOL_N; i++) begin
        tag_pool[i] = (i < 4) ? 48'(i) : 48'({$urandom, $urandom});
      end
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if ($urandom_range(0, 9) == 0) begin
          // noise: any address at all
          addr = 48'({$urandom, $urandom});
        end else begin
          // mostly a handful of sets, now and then any set
          set_pick = ($urandom_range(0, 3) == 0) ? 64'($urandom) : 64'($urandom_range(0, 3));
          set_pick &= (64'd1 << eff_s) - 64'd1;
          wide = (64'(tag_pool[$urandom_range(0, POOL_N - 1)]) << (int'(cur_off) + eff_s))
               | (set_pick << cur_off)
               | ({$urandom, $urandom} & ((64'd1 << cur_off) - 64'd1));
          addr = wide[47:0];
        end
        send_req(addr, 1'($urandom), 1'b0, '0);
      end
    end

    // let everything drain, then watch a little longer for stray results
    settle();
    repeat (16) @(posedge clk);
    if (lookup_errors == 0) begin
      $display("set_assoc_cache_tag_controller_core verification clean");
    end else begin
      $display("set_assoc_cache_tag_controller_core verification failed");
    end
    $finish;
  end

  // watchdog, far beyond the slowest correct run
  initial begin
    #400000;
    $display("set_assoc_cache_tag_controller_core verification failed");
    $finish;
  end

endmodule
